>>> sv/mfb_pkg.sv
// Shared types, constants and helper functions of the mono framebuffer draw engine.
package mfb_pkg;

  localparam int DisplayWidth  = 128;
  localparam int DisplayHeight = 64;
  localparam int PageCount     = (DisplayHeight + 7) / 8;
  localparam int StoreBytes    = DisplayWidth * PageCount;
  localparam int AddrW         = $clog2(StoreBytes);
  localparam int CoordW        = 12;
  localparam int SqW           = 19;
  localparam int QueueDepth    = 2;

  localparam logic [3:0] ModePixel     = 4'd0;
  localparam logic [3:0] ModeHline     = 4'd1;
  localparam logic [3:0] ModeVline     = 4'd2;
  localparam logic [3:0] ModeRect      = 4'd3;
  localparam logic [3:0] ModeFillRect  = 4'd4;
  localparam logic [3:0] ModeRoundRect = 4'd5;
  localparam logic [3:0] ModeFillRound = 4'd6;
  localparam logic [3:0] ModeCircle    = 4'd7;
  localparam logic [3:0] ModeFillCirc  = 4'd8;
  localparam logic [3:0] ModeReadByte  = 4'd9;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [SqW-1:0] sq_t;

  typedef enum logic [2:0] {
    OpBoxes = 3'd0,
    OpRing  = 3'd1,
    OpDisc  = 3'd2,
    OpRead  = 3'd3,
    OpNone  = 3'd4
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [3:0]        mode;
    coord_t            x;
    coord_t            y;
    coord_t            w;
    coord_t            h;
    logic signed [8:0] r;
    logic              ink;
  } cmd_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } box_t;

  typedef struct packed {
    logic clearing;
    logic idle;
  } stat_t;

  function automatic logic on_screen(coord_t px, coord_t py);
    return (px >= 0) && (px < coord_t'(DisplayWidth)) &&
           (py >= 0) && (py < coord_t'(DisplayHeight));
  endfunction

  function automatic logic [AddrW-1:0] byte_addr(coord_t px, coord_t py);
    logic [CoordW-1:0] page;
    logic [31:0]       sum;
    page = CoordW'(unsigned'(py) >> 3);
    sum  = 32'(unsigned'(px)) + 32'(page) * 32'(DisplayWidth);
    return sum[AddrW-1:0];
  endfunction

  // One segment of a box-based command; unused segments come back empty.
  function automatic box_t box_seg(cmd_t c, logic [2:0] seg);
    box_t b;
    b = '{x: c.x, y: c.y, w: coord_t'(0), h: coord_t'(1)};
    case (c.mode)
      ModePixel: begin
        if (seg == 3'd0) b.w = coord_t'(1);
      end
      ModeHline: begin
        if (seg == 3'd0) b.w = c.w;
      end
      ModeVline: begin
        if (seg == 3'd0) begin
          b.w = coord_t'(1);
          b.h = c.h;
        end
      end
      ModeRect: begin
        case (seg)
          3'd0: b.w = c.w;
          3'd1: begin
            b.w = c.w;
            b.y = c.y + c.h - coord_t'(1);
          end
          3'd2: begin
            b.w = coord_t'(1);
            b.h = c.h;
          end
          3'd3: begin
            b.w = coord_t'(1);
            b.h = c.h;
            b.x = c.x + c.w - coord_t'(1);
          end
          default: b.w = coord_t'(0);
        endcase
        if (!((c.w > 0) && (c.h > 0))) b.w = coord_t'(0);
      end
      ModeFillRect: begin
        if (seg == 3'd0) begin
          b.w = c.w;
          b.h = c.h;
        end
      end
      ModeRoundRect: begin
        case (seg)
          3'd0: begin
            b.x = c.x + coord_t'(2);
            b.w = c.w - coord_t'(4);
          end
          3'd1: begin
            b.x = c.x + coord_t'(2);
            b.y = c.y + c.h - coord_t'(1);
            b.w = c.w - coord_t'(4);
          end
          3'd2: begin
            b.y = c.y + coord_t'(2);
            b.w = coord_t'(1);
            b.h = c.h - coord_t'(4);
          end
          3'd3: begin
            b.x = c.x + c.w - coord_t'(1);
            b.y = c.y + coord_t'(2);
            b.w = coord_t'(1);
            b.h = c.h - coord_t'(4);
          end
          3'd4: begin
            b.x = c.x + coord_t'(1);
            b.y = c.y + coord_t'(1);
            b.w = coord_t'(1);
          end
          3'd5: begin
            b.x = c.x + c.w - coord_t'(2);
            b.y = c.y + coord_t'(1);
            b.w = coord_t'(1);
          end
          3'd6: begin
            b.x = c.x + coord_t'(1);
            b.y = c.y + c.h - coord_t'(2);
            b.w = coord_t'(1);
          end
          default: begin
            b.x = c.x + c.w - coord_t'(2);
            b.y = c.y + c.h - coord_t'(2);
            b.w = coord_t'(1);
          end
        endcase
      end
      ModeFillRound: begin
        case (seg)
          3'd0: begin
            b.x = c.x + coord_t'(1);
            b.w = c.w - coord_t'(2);
            b.h = c.h;
          end
          3'd1: begin
            b.y = c.y + coord_t'(1);
            b.w = c.w;
            b.h = c.h - coord_t'(2);
          end
          default: b.w = coord_t'(0);
        endcase
      end
      default: b.w = coord_t'(0);
    endcase
    return b;
  endfunction

endpackage

>>> sv/mfb_front.sv
// Front end: accepts drawing requests and classifies them into queue entries.
module mfb_front (
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [55:0]   s_axis_tdata_i,
  input  logic [3:0]    s_axis_tuser_i,
  input  logic          q_ready_i,
  input  mfb_pkg::stat_t stat_i,
  output logic          q_push_o,
  output mfb_pkg::cmd_t q_cmd_o
);

  mfb_pkg::op_e op;

  always_comb begin
    case (s_axis_tuser_i) inside
      [mfb_pkg::ModePixel:mfb_pkg::ModeFillRound]: op = mfb_pkg::OpBoxes;
      mfb_pkg::ModeCircle:   op = mfb_pkg::OpRing;
      mfb_pkg::ModeFillCirc: op = mfb_pkg::OpDisc;
      mfb_pkg::ModeReadByte: op = mfb_pkg::OpRead;
      default:               op = mfb_pkg::OpNone;
    endcase
  end

  // hold off requests during the clearing pass
  assign s_axis_tready_o = q_ready_i & ~stat_i.clearing;
  assign q_push_o        = s_axis_tvalid_i & s_axis_tready_o;

  assign q_cmd_o.op   = op;
  assign q_cmd_o.mode = s_axis_tuser_i;
  assign q_cmd_o.x    = mfb_pkg::coord_t'(signed'(s_axis_tdata_i[9:0]));
  assign q_cmd_o.y    = mfb_pkg::coord_t'(signed'(s_axis_tdata_i[19:10]));
  assign q_cmd_o.w    = mfb_pkg::coord_t'(signed'(s_axis_tdata_i[29:20]));
  assign q_cmd_o.h    = mfb_pkg::coord_t'(signed'(s_axis_tdata_i[39:30]));
  assign q_cmd_o.r    = signed'(s_axis_tdata_i[48:40]);
  assign q_cmd_o.ink  = s_axis_tdata_i[49];

endmodule

>>> sv/mfb_queue.sv
// Short command queue between the front end and the raster back end.
module mfb_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mfb_pkg::cmd_t cmd_i,
  output logic          ready_o,
  input  logic          pop_i,
  output logic          valid_o,
  output mfb_pkg::cmd_t cmd_o
);

  mfb_pkg::cmd_t entry_q [mfb_pkg::QueueDepth];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;

  assign ready_o = (count_q != 2'(mfb_pkg::QueueDepth));
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
      count_d  = count_d + 2'd1;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
      count_d  = count_d - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= cmd_i;
  end

endmodule

>>> sv/mfb_back.sv
// Back end: rasterizes queued commands into the page framebuffer by read-modify-write.
module mfb_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  mfb_pkg::cmd_t q_cmd_i,
  output logic          q_pop_o,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [7:0]    m_axis_tdata_o,
  output logic [3:0]    m_axis_tuser_o,
  output mfb_pkg::stat_t stat_o
);

  typedef enum logic [6:0] {
    SClear = 7'b0000001,
    SIdle  = 7'b0000010,
    SSeg   = 7'b0000100,
    SGen   = 7'b0001000,
    SWr    = 7'b0010000,
    SRd    = 7'b0100000,
    SOut   = 7'b1000000
  } state_e;

  state_e                      state_q, state_d;
  mfb_pkg::cmd_t               cmd_q, cmd_d;
  logic [2:0]                  seg_q, seg_d;
  mfb_pkg::coord_t             bx_q, bx_d, by_q, by_d, bw_q, bw_d, bh_q, bh_d;
  mfb_pkg::coord_t             col_q, col_d, row_q, row_d;
  mfb_pkg::coord_t             ra_q, ra_d, rb_q, rb_d, re_q, re_d;
  logic [2:0]                  k_q, k_d;
  mfb_pkg::coord_t             dx_q, dx_d, dy_q, dy_d;
  mfb_pkg::sq_t                sq_q, sq_d, rr_q, rr_d, dy2_q, dy2_d;
  logic [mfb_pkg::AddrW-1:0]   addr_q, addr_d, clr_q, clr_d;
  logic [7:0]                  mask_q, mask_d, data_q, data_d;
  logic                        res_valid_q, res_valid_d;
  logic [7:0]                  res_data_q, res_data_d;
  logic [3:0]                  res_mode_q, res_mode_d;

  logic [7:0]                  mem_q [mfb_pkg::StoreBytes];
  logic [7:0]                  rd_q;
  logic                        mem_we, mem_re;
  logic [mfb_pkg::AddrW-1:0]   mem_wa, mem_ra;
  logic [7:0]                  mem_wd;

  mfb_pkg::coord_t             px, py, rx;
  mfb_pkg::box_t               seg_box;
  logic                        hit, gen_end, adv;
  mfb_pkg::coord_t             nb1, ne1, na1, ne2;
  logic [8:0]                  r_mag;
  mfb_pkg::sq_t                r_sq;

  assign rx      = mfb_pkg::coord_t'(cmd_q.r);
  assign seg_box = mfb_pkg::box_seg(cmd_q, seg_q);
  assign r_mag   = unsigned'(cmd_q.r);
  assign r_sq    = mfb_pkg::sq_t'(r_mag) * mfb_pkg::sq_t'(r_mag);

  // candidate pixel of the current generator step
  always_comb begin
    px = bx_q + col_q;
    py = by_q + row_q;
    case (cmd_q.op)
      mfb_pkg::OpRing: begin
        case (k_q)
          3'd0: begin px = cmd_q.x + ra_q; py = cmd_q.y + rb_q; end
          3'd1: begin px = cmd_q.x + rb_q; py = cmd_q.y + ra_q; end
          3'd2: begin px = cmd_q.x - rb_q; py = cmd_q.y + ra_q; end
          3'd3: begin px = cmd_q.x - ra_q; py = cmd_q.y + rb_q; end
          3'd4: begin px = cmd_q.x - ra_q; py = cmd_q.y - rb_q; end
          3'd5: begin px = cmd_q.x - rb_q; py = cmd_q.y - ra_q; end
          3'd6: begin px = cmd_q.x + rb_q; py = cmd_q.y - ra_q; end
          default: begin px = cmd_q.x + ra_q; py = cmd_q.y - rb_q; end
        endcase
      end
      mfb_pkg::OpDisc: begin
        px = cmd_q.x + dx_q;
        py = cmd_q.y + dy_q;
      end
      default: ;
    endcase
  end

  assign hit = mfb_pkg::on_screen(px, py) &&
               ((cmd_q.op != mfb_pkg::OpDisc) || (sq_q <= rr_q));

  // midpoint step of the ring
  always_comb begin
    nb1 = rb_q + mfb_pkg::coord_t'(1);
    ne1 = (re_q <= 0) ? (re_q + (nb1 <<< 1) + mfb_pkg::coord_t'(1)) : re_q;
    if (ne1 > 0) begin
      na1 = ra_q - mfb_pkg::coord_t'(1);
      ne2 = ne1 - (na1 <<< 1) - mfb_pkg::coord_t'(1);
    end else begin
      na1 = ra_q;
      ne2 = ne1;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    seg_d       = seg_q;
    bx_d        = bx_q;
    by_d        = by_q;
    bw_d        = bw_q;
    bh_d        = bh_q;
    col_d       = col_q;
    row_d       = row_q;
    ra_d        = ra_q;
    rb_d        = rb_q;
    re_d        = re_q;
    k_d         = k_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    sq_d        = sq_q;
    rr_d        = rr_q;
    dy2_d       = dy2_q;
    addr_d      = addr_q;
    mask_d      = mask_q;
    data_d      = data_q;
    clr_d       = clr_q;
    res_valid_d = res_valid_q & ~m_axis_tready_i;
    res_data_d  = res_data_q;
    res_mode_d  = res_mode_q;
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = addr_q;
    mem_wd      = 8'd0;
    mem_re      = 1'b0;
    mem_ra      = mfb_pkg::byte_addr(px, py);
    adv         = 1'b0;
    gen_end     = 1'b0;

    case (state_q)
      SClear: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        clr_d  = clr_q + 1'b1;
        if (clr_q == mfb_pkg::AddrW'(mfb_pkg::StoreBytes - 1)) state_d = SIdle;
      end
      SIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          seg_d   = 3'd0;
          data_d  = 8'd0;
          state_d = SSeg;
        end
      end
      SSeg: begin
        case (cmd_q.op)
          mfb_pkg::OpBoxes: begin
            if ((seg_box.w > 0) && (seg_box.h > 0)) begin
              bx_d    = seg_box.x;
              by_d    = seg_box.y;
              bw_d    = seg_box.w;
              bh_d    = seg_box.h;
              col_d   = '0;
              row_d   = '0;
              state_d = SGen;
            end else if (seg_q == 3'd7) begin
              state_d = SOut;
            end else begin
              seg_d = seg_q + 3'd1;
            end
          end
          mfb_pkg::OpRing: begin
            ra_d    = rx;
            rb_d    = '0;
            re_d    = '0;
            k_d     = 3'd0;
            state_d = (cmd_q.r < 0) ? SOut : SGen;
          end
          mfb_pkg::OpDisc: begin
            dx_d    = -rx;
            dy_d    = -rx;
            rr_d    = r_sq;
            dy2_d   = r_sq;
            sq_d    = r_sq <<< 1;
            state_d = (cmd_q.r < 0) ? SOut : SGen;
          end
          mfb_pkg::OpRead: begin
            mem_ra = mfb_pkg::byte_addr(cmd_q.x, cmd_q.y);
            if (mfb_pkg::on_screen(cmd_q.x, cmd_q.y)) begin
              mem_re  = 1'b1;
              state_d = SRd;
            end else begin
              state_d = SOut;
            end
          end
          default: state_d = SOut;
        endcase
      end
      SGen: begin
        if (hit) begin
          mem_re  = 1'b1;
          addr_d  = mem_ra;
          mask_d  = 8'd1 << py[2:0];
          state_d = SWr;
        end else begin
          adv = 1'b1;
        end
      end
      SWr: begin
        mem_we = 1'b1;
        mem_wd = cmd_q.ink ? (rd_q | mask_q) : (rd_q & ~mask_q);
        adv    = 1'b1;
      end
      SRd: begin
        data_d  = rd_q;
        state_d = SOut;
      end
      SOut: begin
        if (!res_valid_q || m_axis_tready_i) begin
          res_valid_d = 1'b1;
          res_data_d  = data_q;
          res_mode_d  = cmd_q.mode;
          state_d     = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase

    // advance the active generator by one candidate pixel
    if (adv) begin
      state_d = SGen;
      case (cmd_q.op)
        mfb_pkg::OpRing: begin
          if (k_q == 3'd7) begin
            k_d  = 3'd0;
            rb_d = nb1;
            ra_d = na1;
            re_d = ne2;
            gen_end = (na1 < nb1);
          end else begin
            k_d = k_q + 3'd1;
          end
        end
        mfb_pkg::OpDisc: begin
          if (dx_q == rx) begin
            dx_d    = -rx;
            dy_d    = dy_q + mfb_pkg::coord_t'(1);
            dy2_d   = dy2_q + mfb_pkg::sq_t'((dy_q <<< 1) + mfb_pkg::coord_t'(1));
            sq_d    = rr_q + dy2_d;
            gen_end = (dy_q == rx);
          end else begin
            dx_d = dx_q + mfb_pkg::coord_t'(1);
            sq_d = sq_q + mfb_pkg::sq_t'((dx_q <<< 1) + mfb_pkg::coord_t'(1));
          end
        end
        default: begin
          if (col_q + mfb_pkg::coord_t'(1) == bw_q) begin
            col_d = '0;
            row_d = row_q + mfb_pkg::coord_t'(1);
            gen_end = (row_q + mfb_pkg::coord_t'(1) == bh_q);
          end else begin
            col_d = col_q + mfb_pkg::coord_t'(1);
          end
        end
      endcase
      if (gen_end) begin
        if ((cmd_q.op == mfb_pkg::OpBoxes) && (seg_q != 3'd7)) begin
          seg_d   = seg_q + 3'd1;
          state_d = SSeg;
        end else begin
          state_d = SOut;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    seg_q      <= seg_d;
    bx_q       <= bx_d;
    by_q       <= by_d;
    bw_q       <= bw_d;
    bh_q       <= bh_d;
    col_q      <= col_d;
    row_q      <= row_d;
    ra_q       <= ra_d;
    rb_q       <= rb_d;
    re_q       <= re_d;
    k_q        <= k_d;
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    sq_q       <= sq_d;
    rr_q       <= rr_d;
    dy2_q      <= dy2_d;
    addr_q     <= addr_d;
    mask_q     <= mask_d;
    data_q     <= data_d;
    res_data_q <= res_data_d;
    res_mode_q <= res_mode_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= mem_q[mem_ra];
  end

  assign m_axis_tvalid_o = res_valid_q;
  assign m_axis_tdata_o  = res_data_q;
  assign m_axis_tuser_o  = res_mode_q;
  assign stat_o.clearing = (state_q == SClear);
  assign stat_o.idle     = (state_q == SIdle);

endmodule

>>> sv/mono_framebuffer_draw_engine.sv
// Top level of the mono framebuffer draw engine: front end, command queue, raster back end.
//
//  channel  | dir | tdata (low bit up)                               | tuser
//  s_axis   | in  | pos_x[9:0] pos_y[19:10] width[29:20] height[39:30] | mode[3:0]
//           |     | radius[48:40] ink[49] zero[55:50]                |
//  m_axis   | out | read_data[7:0]                                   | mode_echo[3:0]
//
// A drawing request reads, then writes back, the framebuffer byte of each on-screen pixel;
// each skipped candidate pixel and each segment takes a step without a memory access; read_byte
// reads a single byte.
// After reset a clearing pass writes all framebuffer bytes, one per cycle (StoreBytes
// bytes, 1024 at 128x64); s_axis_tready is low during it.
// A two-entry queue and the result register let either side stall on its own.
module mono_framebuffer_draw_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,  // pos_x, pos_y, width, height, radius, ink
  input  logic [3:0]  s_axis_tuser_i,  // mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // read_data
  output logic [3:0]  m_axis_tuser_o   // mode_echo
);

  mfb_pkg::cmd_t  push_cmd, head_cmd;
  mfb_pkg::stat_t stat;
  logic           q_push, q_ready, q_valid, q_pop;

  mfb_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_ready_i       (q_ready),
    .stat_i          (stat),
    .q_push_o        (q_push),
    .q_cmd_o         (push_cmd)
  );

  mfb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  mfb_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_cmd_i         (head_cmd),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .stat_o          (stat)
  );

  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !s_axis_tready_o)
    else $error("request accepted during clearing pass");

  a_clear_runs_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stat.clearing |=> !stat.clearing)
    else $error("clearing pass restarted");

  a_draw_returns_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != mfb_pkg::ModeReadByte)) |->
      (m_axis_tdata_o == 8'd0))
    else $error("drawing request returned nonzero data");

  a_pop_only_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (stat.idle && q_valid))
    else $error("queue popped outside idle");

endmodule

>>> dv/tb_mono_framebuffer_draw_engine.sv
// Testbench for the mono framebuffer draw engine: random and directed drawing requests, checked on read-back.
module tb_mono_framebuffer_draw_engine;

  localparam int CycleLimit = 20_000_000;

  typedef struct {
    logic [3:0] mode;
    int         x;
    int         y;
    int         w;
    int         h;
    int         r;
    bit         ink;
  } draw_req_t;

  typedef struct {
    logic [7:0] data;
    logic [3:0] mode;
  } reply_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [55:0] s_axis_tdata_i;  // pos_x, pos_y, width, height, radius, ink
  logic [3:0]  s_axis_tuser_i;  // mode
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [7:0]  m_axis_tdata_o;  // read_data
  logic [3:0]  m_axis_tuser_o;  // mode_echo

  mono_framebuffer_draw_engine dut (.*);

  draw_req_t  pending_reqs[$];
  reply_t     expected_replies[$];
  logic [7:0] shadow_fb[mfb_pkg::StoreBytes];
  draw_req_t  cur_req;
  int         accepted_reqs;
  int         send_gap;
  int         recv_gap;
  int         hold_cnt;
  bit         hold_done;
  logic       hold_q;
  int         err_cnt;
  int         cycle_cnt;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Shadow framebuffer model
  function automatic void put_px(int x, int y, bit ink);
    int idx;
    if (x < 0 || x >= mfb_pkg::DisplayWidth || y < 0 || y >= mfb_pkg::DisplayHeight) return;
    idx = x + (y / 8) * mfb_pkg::DisplayWidth;
    shadow_fb[idx][y % 8] = ink;
  endfunction

  function automatic void span_x(int x, int y, int len, bit ink);
    for (int i = 0; i < len; i++) put_px(x + i, y, ink);
  endfunction

  function automatic void span_y(int x, int y, int len, bit ink);
    for (int i = 0; i < len; i++) put_px(x, y + i, ink);
  endfunction

  function automatic void fill_box(int x, int y, int w, int h, bit ink);
    for (int j = 0; j < h; j++) span_x(x, y + j, w, ink);
  endfunction

  function automatic void draw_ring(int cx, int cy, int r, bit ink);
    int a, b, e;
    a = r;
    b = 0;
    e = 0;
    while (a >= b) begin
      put_px(cx + a, cy + b, ink);
      put_px(cx + b, cy + a, ink);
      put_px(cx - b, cy + a, ink);
      put_px(cx - a, cy + b, ink);
      put_px(cx - a, cy - b, ink);
      put_px(cx - b, cy - a, ink);
      put_px(cx + b, cy - a, ink);
      put_px(cx + a, cy - b, ink);
      b++;
      if (e <= 0) e += 2 * b + 1;
      if (e > 0) begin
        a--;
        e -= 2 * a + 1;
      end
    end
  endfunction

  function automatic void draw_disc(int cx, int cy, int r, bit ink);
    for (int dy = -r; dy <= r; dy++)
      for (int dx = -r; dx <= r; dx++)
        if (dx * dx + dy * dy <= r * r) put_px(cx + dx, cy + dy, ink);
  endfunction

  function automatic void rasterize_req(draw_req_t q);
    reply_t rep;
    rep.data = 8'h00;
    rep.mode = q.mode;
    case (q.mode)
      mfb_pkg::ModePixel: put_px(q.x, q.y, q.ink);
      mfb_pkg::ModeHline: span_x(q.x, q.y, q.w, q.ink);
      mfb_pkg::ModeVline: span_y(q.x, q.y, q.h, q.ink);
      mfb_pkg::ModeRect: begin
        if (q.w > 0 && q.h > 0) begin
          span_x(q.x, q.y, q.w, q.ink);
          span_x(q.x, q.y + q.h - 1, q.w, q.ink);
          span_y(q.x, q.y, q.h, q.ink);
          span_y(q.x + q.w - 1, q.y, q.h, q.ink);
        end
      end
      mfb_pkg::ModeFillRect: fill_box(q.x, q.y, q.w, q.h, q.ink);
      mfb_pkg::ModeRoundRect: begin
        span_x(q.x + 2, q.y, q.w - 4, q.ink);
        span_x(q.x + 2, q.y + q.h - 1, q.w - 4, q.ink);
        span_y(q.x, q.y + 2, q.h - 4, q.ink);
        span_y(q.x + q.w - 1, q.y + 2, q.h - 4, q.ink);
        put_px(q.x + 1, q.y + 1, q.ink);
        put_px(q.x + q.w - 2, q.y + 1, q.ink);
        put_px(q.x + 1, q.y + q.h - 2, q.ink);
        put_px(q.x + q.w - 2, q.y + q.h - 2, q.ink);
      end
      mfb_pkg::ModeFillRound: begin
        fill_box(q.x + 1, q.y, q.w - 2, q.h, q.ink);
        fill_box(q.x, q.y + 1, q.w, q.h - 2, q.ink);
      end
      mfb_pkg::ModeCircle: draw_ring(q.x, q.y, q.r, q.ink);
      mfb_pkg::ModeFillCirc: draw_disc(q.x, q.y, q.r, q.ink);
      mfb_pkg::ModeReadByte: begin
        if (q.x >= 0 && q.x < mfb_pkg::DisplayWidth &&
            q.y >= 0 && q.y < mfb_pkg::DisplayHeight)
          rep.data = shadow_fb[q.x + (q.y / 8) * mfb_pkg::DisplayWidth];
      end
      default: ;
    endcase
    expected_replies.push_back(rep);
  endfunction

  // Stimulus helpers
  function automatic draw_req_t make_req(logic [3:0] mode, int x, int y, int w, int h,
                                         int r, bit ink);
    draw_req_t q;
    q = '{mode: mode, x: x, y: y, w: w, h: h, r: r, ink: ink};
    return q;
  endfunction

  function automatic int full10();
    return int'($signed(10'($urandom)));
  endfunction

  function automatic int rand_coord(int span);
    if ($urandom_range(0, 39) == 0) return full10();
    return $urandom_range(0, span + 20) - 10;
  endfunction

  function automatic int rand_len(bit allow_big);
    if (allow_big && $urandom_range(0, 39) == 0) return full10();
    return $urandom_range(0, 33) - 3;
  endfunction

  function automatic draw_req_t rand_req();
    draw_req_t q;
    int        pick;
    bit        big;
    pick = $urandom_range(0, 15);
    if (pick < 4) q.mode = mfb_pkg::ModeReadByte;
    else if (pick < 13) q.mode = 4'($urandom_range(0, 8));
    else if (pick < 15) q.mode = mfb_pkg::ModeReadByte;
    else q.mode = 4'($urandom_range(10, 15));
    big = !(q.mode inside {mfb_pkg::ModeFillRect, mfb_pkg::ModeFillRound,
                           mfb_pkg::ModeFillCirc});
    q.x = rand_coord(mfb_pkg::DisplayWidth);
    q.y = rand_coord(mfb_pkg::DisplayHeight);
    q.w = rand_len(big);
    q.h = rand_len(big);
    if (big && $urandom_range(0, 39) == 0) q.r = int'($signed(9'($urandom)));
    else q.r = $urandom_range(0, 22) - 2;
    q.ink = ($urandom_range(0, 3) != 0);
    // Keep fills cheap but still reach the wide length bits on one side
    if (!big && $urandom_range(0, 29) == 0) begin
      if ($urandom_range(0, 1)) q.w = full10();
      else q.h = full10();
    end
    return q;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    err_cnt++;
    $display("MISMATCH %s: got %0h expected %0h", what, got, want);
  endtask

  // Driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tuser_i  <= '0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        rasterize_req(cur_req);
        accepted_reqs++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_reqs.size() > 0 &&
                     (pending_reqs.size() < 300 || $urandom_range(0, 11) != 0)) begin
          cur_req = pending_reqs.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= cur_req.mode;
          s_axis_tdata_i  <= {6'd0, cur_req.ink, 9'(cur_req.r), 10'(cur_req.h),
                              10'(cur_req.w), 10'(cur_req.y), 10'(cur_req.x)};
        end else begin
          if (pending_reqs.size() > 0) send_gap = $urandom_range(0, 7);
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off once the run is under way
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt  = 0;
      hold_done = 1'b0;
      hold_q    <= 1'b0;
    end else begin
      if (!hold_done && accepted_reqs >= 600) begin
        hold_cnt  = 3000;
        hold_done = 1'b1;
      end else if (hold_cnt > 0) begin
        hold_cnt--;
      end
      hold_q <= (hold_cnt > 0);
    end
  end

  // Monitor
  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      recv_gap = 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("unexpected reply", {4'd0, m_axis_tuser_o}, 8'h00);
        end else begin
          want = expected_replies.pop_front();
          if (m_axis_tuser_o !== want.mode)
            report_mismatch("mode_echo", {4'd0, m_axis_tuser_o}, {4'd0, want.mode});
          if (m_axis_tdata_o !== want.data)
            report_mismatch("read_data", m_axis_tdata_o, want.data);
        end
      end
      if (hold_q) begin
        m_axis_tready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready_i <= 1'b0;
      end else begin
        if (pending_reqs.size() >= 300 && $urandom_range(0, 11) == 0)
          recv_gap = $urandom_range(1, 8);
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    accepted_reqs = 0;
    err_cnt = 0;
    cycle_cnt = 0;
    foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;

    pending_reqs.push_back(make_req(mfb_pkg::ModeReadByte, 5, 5, 0, 0, 0, 1'b0));
    pending_reqs.push_back(make_req(mfb_pkg::ModePixel, 0, 0, 0, 0, 0, 1'b1));
    pending_reqs.push_back(make_req(mfb_pkg::ModePixel, 127, 63, 0, 0, 0, 1'b1));
    pending_reqs.push_back(make_req(mfb_pkg::ModePixel, -1, 128, 0, 0, 0, 1'b1));
    pending_reqs.push_back(make_req(mfb_pkg::ModeReadByte, 127, 63, 0, 0, 0, 1'b0));
    pending_reqs.push_back(make_req(mfb_pkg::ModeHline, -512, 3, 511, 0, 0, 1'b1));
    pending_reqs.push_back(make_req(mfb_pkg::ModeHline, 10, 4, -512, 0, 0, 1'b1));
    pending_reqs.push_back(make_req(mfb_pkg::ModeVline, 511, 0, 0, 40, 0, 1'b1));
    pending_reqs.push_back(make_req(mfb_pkg::ModeVline, 20, -10, 0, 30, 0, 1'b1));
    pending_reqs.push_back(make_req(mfb_pkg::ModeRect, 30, 10, 20, 0, 0, 1'b1));
    pending_reqs.push_back(make_req(mfb_pkg::ModeRect, 30, 10, 20, 12, 0, 1'b1));
    pending_reqs.push_back(make_req(mfb_pkg::ModeFillRect, -512, -512, 511, 511, 0, 1'b1));
    pending_reqs.push_back(make_req(mfb_pkg::ModeFillRect, 40, 20, 30, 20, 0, 1'b0));
    pending_reqs.push_back(make_req(mfb_pkg::ModeRoundRect, 60, 30, 0, 0, 0, 1'b1));
    pending_reqs.push_back(make_req(mfb_pkg::ModeRoundRect, 60, 30, 20, 10, 0, 1'b1));
    pending_reqs.push_back(make_req(mfb_pkg::ModeFillRound, 80, 40, 9, 7, 0, 1'b1));
    pending_reqs.push_back(make_req(mfb_pkg::ModeCircle, 64, 32, 0, 0, 0, 1'b0));
    pending_reqs.push_back(make_req(mfb_pkg::ModeCircle, 64, 32, 0, 0, 255, 1'b1));
    pending_reqs.push_back(make_req(mfb_pkg::ModeCircle, 64, 32, 0, 0, -1, 1'b0));
    pending_reqs.push_back(make_req(mfb_pkg::ModeFillCirc, 100, 20, 0, 0, -256, 1'b0));
    pending_reqs.push_back(make_req(mfb_pkg::ModeFillCirc, 100, 20, 0, 0, 9, 1'b0));
    pending_reqs.push_back(make_req(mfb_pkg::ModeReadByte, 100, 20, 0, 0, 0, 1'b0));
    pending_reqs.push_back(make_req(mfb_pkg::ModeReadByte, 64, -1, 0, 0, 0, 1'b0));
    pending_reqs.push_back(make_req(4'd15, 3, 3, 0, 0, 0, 1'b1));
    repeat (2000) pending_reqs.push_back(rand_req());

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() > 0 || s_axis_tvalid_i || expected_replies.size() > 0)
      @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (err_cnt == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> mono_framebuffer_draw_engine.f
sv/mfb_pkg.sv
sv/mfb_front.sv
sv/mfb_queue.sv
sv/mfb_back.sv
sv/mono_framebuffer_draw_engine.sv
dv/tb_mono_framebuffer_draw_engine.sv
